FILE: design/gvs_pkg.sv
// Package: types, constants and helpers for the greedy variant selector.
package gvs_pkg;

  localparam int unsigned PoolMaxDefault      = 16;
  localparam int unsigned CostFracBitsDefault = 16;
  localparam int unsigned CfgIdxW             = 3;
  localparam int unsigned CfgDataW            = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POOL_SIZE      = 3'd0,
    CFG_SKIP_LENGTH    = 3'd1,
    CFG_EXPLORE_LENGTH = 3'd2,
    CFG_EXPLORE_PERIOD = 3'd3,
    CFG_EXPLOIT_PERIOD = 3'd4,
    CFG_INITIAL_EXPL   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_INITIAL = 2'd1,
    MODE_RANDOM  = 2'd2,
    MODE_EXPLOIT = 2'd3
  } mode_e;

  typedef struct packed {
    logic        func;
    logic [47:0] runtime_total;
    logic [39:0] tuples_total;
    logic [15:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  variant_index;
    logic [1:0]  decision_mode;
    logic        measure_started;
    logic        cost_valid;
    logic [47:0] measured_cost;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  pool_size;
    logic [15:0] skip_length;
    logic [15:0] explore_length;
    logic [23:0] explore_period;
    logic [23:0] exploit_period;
    logic        initial_exploration;
  } cfg_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // latch input item, evaluate conditions
    logic div_start; // start cost division
    logic div_step;  // one restoring-division step
    logic mod_start; // start random modulo
    logic mod_step;
    logic scan_start;
    logic scan_step;
    logic commit;    // update state, build result
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic need_div;
    logic need_mod;
    logic need_scan;
    logic div_done;
    logic mod_done;
    logic scan_done;
  } dp_sts_t;

endpackage

FILE: design/greedy_variant_selector.sv
// Top level of the greedy variant selector.
// Usage:
//  - Input channel (in_valid_i/in_ready_o/in_item_i): one transfer per call
//    or finish query. Output channel returns exactly one result per item.
//  - Config port: cfg_we_i/cfg_idx_i/cfg_data_i, write while idle only.
// Processing: every item is loaded, evaluated and committed. Closing a
//  measurement adds one divider step per quotient bit (48+COST_FRAC_BITS,
//  64 by default); random exploration adds 16 modulo steps, exploitation
//  adds one scan step per variant in the pool.
// Flow: one item at a time; the next item is taken only after the result
//  of the last one has been transferred. The serial divider dominates.
// Reset: counters clear, table reads as zero through valid bits, registers
//  take their defaults. No clearing pass.
// Stall: the result sits in the output register; no new item is taken
//  until that result is transferred.
module greedy_variant_selector import gvs_pkg::*; #(
  parameter int unsigned COST_FRAC_BITS = CostFracBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o
);
  dp_cmd_t   cmd;
  dp_sts_t   sts;
  out_item_t res;

  gvs_datapath #(.COST_FRAC_BITS(COST_FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .item_i(in_item_i), .cmd_i(cmd), .sts_o(sts), .result_o(res)
  );

  gvs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd), .result_i(res), .result_o(out_item_o)
  );
endmodule

FILE: design/gvs_datapath.sv
// Datapath: counters, snapshots, cost table, serial divider, modulo and table scan.
module gvs_datapath import gvs_pkg::*; #(
  parameter int unsigned COST_FRAC_BITS = CostFracBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  in_item_t  item_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output out_item_t result_o
);
  localparam int unsigned POOL_MAX = PoolMaxDefault;
  localparam int unsigned IdxW  = $clog2(POOL_MAX);
  localparam int unsigned CntW  = $clog2(POOL_MAX + 1);
  localparam int unsigned NumW  = 48 + COST_FRAC_BITS;
  localparam int unsigned DStW  = $clog2(NumW + 1);

  cfg_t cfg_q;
  logic [31:0] call_q, next_dec_q, meas_start_q, next_exp_q;
  logic [3:0]  cur_q;
  logic        has_cur_q;
  logic [47:0] snap_rt_q;
  logic [39:0] snap_tu_q;
  logic [47:0] table_q [POOL_MAX];
  logic [POOL_MAX-1:0] tvalid_q;

  in_item_t    item_q;
  logic        finish_q, decide_q, initial_q, random_q;

  // effective pool size
  logic [CntW-1:0] pool;
  always_comb begin
    if (cfg_q.pool_size == 5'd0) pool = CntW'(1);
    else if ({27'd0, cfg_q.pool_size} > 32'(POOL_MAX)) pool = CntW'(POOL_MAX);
    else pool = CntW'(cfg_q.pool_size);
  end

  logic [16:0] win;
  logic [47:0] pool_win;
  logic [31:0] exp_start;
  assign win       = {1'b0, cfg_q.skip_length} + {1'b0, cfg_q.explore_length};
  assign pool_win  = 48'(22'(pool) * 22'(win));
  assign exp_start = cfg_q.initial_exploration ?
                     (pool_win[31:0] + {8'd0, cfg_q.explore_period}) : 32'd0;

  // config writes; next_explore_at follows them before the first call
  cfg_t cfg_d;
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_POOL_SIZE:      cfg_d.pool_size = cfg_data_i[4:0];
        CFG_SKIP_LENGTH:    cfg_d.skip_length = cfg_data_i[15:0];
        CFG_EXPLORE_LENGTH: cfg_d.explore_length = cfg_data_i[15:0];
        CFG_EXPLORE_PERIOD: cfg_d.explore_period = cfg_data_i;
        CFG_EXPLOIT_PERIOD: cfg_d.exploit_period = cfg_data_i;
        CFG_INITIAL_EXPL:   cfg_d.initial_exploration = cfg_data_i[0];
        default: ;
      endcase
    end
  end
  logic cfg_hit;
  assign cfg_hit = cfg_we_i && (cfg_idx_i <= CfgIdxW'(CFG_INITIAL_EXPL));
  logic cfg_pend_q; // registered config-write flag; triggers the explore start recompute

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= '{5'd1, 16'd0, 16'd1, 24'd1000, 24'd1000, 1'b1};
      cfg_pend_q <= 1'b1;
    end else begin
      cfg_q      <= cfg_d;
      cfg_pend_q <= cfg_hit;
    end
  end

  // decision conditions, registered at load
  logic finish_d, decide_d;
  assign decide_d = !item_i.func && (call_q == next_dec_q);
  assign finish_d = has_cur_q && (item_i.func ? (call_q > meas_start_q) : decide_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q    <= item_i;
      finish_q  <= finish_d;
      decide_q  <= decide_d;
      initial_q <= cfg_q.initial_exploration && (win != 17'd0) &&
                   ({16'd0, call_q} < pool_win);
      random_q  <= call_q >= next_exp_q;
    end
  end

  // cost divider: restoring, one bit per step
  logic [47:0] rd, rem_w;
  logic [39:0] td;
  logic [NumW-1:0] num_q, quo_q;
  logic [40:0] rem_q;
  logic [DStW-1:0] dcnt_q;
  logic [40:0] rem_sh, rem_sub;
  assign rd  = item_q.runtime_total - snap_rt_q;
  assign td  = item_q.tuples_total - snap_tu_q;
  assign rem_w = '0;
  assign rem_sh  = {rem_q[39:0], num_q[NumW-1]};
  assign rem_sub = rem_sh - {1'b0, td};
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q  <= NumW'(rd) << COST_FRAC_BITS;
      quo_q  <= '0;
      rem_q  <= '0;
      dcnt_q <= DStW'(NumW);
    end else if (cmd_i.div_step) begin
      num_q  <= num_q << 1;
      if (!rem_sub[40]) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
      dcnt_q <= dcnt_q - DStW'(1);
    end
  end
  // quotient at or above 2^48 saturates
  logic [47:0] cost;
  always_comb begin
    if (!finish_q || td == 40'd0) cost = rem_w;
    else if (|(quo_q >> 48)) cost = '1;
    else cost = quo_q[47:0];
  end

  // random modulo: repeated shift-subtract over 16 bits
  logic [15:0] mrem_q;
  logic [4:0]  mcnt_q;
  logic [15:0] mnum_q;
  logic [16:0] msh, msub;
  assign msh  = {mrem_q, mnum_q[15]};
  assign msub = msh - 17'(pool);
  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_start) begin
      mnum_q <= item_q.random_value;
      mrem_q <= '0;
      mcnt_q <= 5'd16;
    end else if (cmd_i.mod_step) begin
      mnum_q <= mnum_q << 1;
      mrem_q <= msub[16] ? msh[15:0] : msub[15:0];
      mcnt_q <= mcnt_q - 5'd1;
    end
  end

  // table scan, one entry per cycle; the cost being closed on this item
  // stands in for the current variant's entry
  logic [CntW-1:0] sidx_q;
  logic [47:0]     best_q;
  logic            found_q;
  logic [IdxW-1:0] bidx_q;
  logic [47:0]     entry;
  always_comb begin
    if (finish_q && sidx_q[IdxW-1:0] == cur_q[IdxW-1:0]) entry = cost;
    else if (tvalid_q[sidx_q[IdxW-1:0]]) entry = table_q[sidx_q[IdxW-1:0]];
    else entry = 48'd0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      sidx_q  <= '0;
      found_q <= 1'b0;
      best_q  <= '0;
      bidx_q  <= '0;
    end else if (cmd_i.scan_step) begin
      if (entry != 48'd0 && (!found_q || entry < best_q)) begin
        best_q  <= entry;
        found_q <= 1'b1;
        bidx_q  <= sidx_q[IdxW-1:0];
      end
      sidx_q <= sidx_q + CntW'(1);
    end
  end

  assign sts_o.need_div  = finish_q;
  assign sts_o.need_mod  = decide_q && !initial_q && random_q;
  assign sts_o.need_scan = decide_q && !initial_q && !random_q;
  assign sts_o.div_done  = dcnt_q == '0;
  assign sts_o.mod_done  = mcnt_q == 5'd0;
  assign sts_o.scan_done = sidx_q == pool;

  // initial round robin index: call / win, small (< POOL_MAX) so use a short search
  logic [3:0] rr_idx;
  always_comb begin
    rr_idx = '0;
    for (int i = 1; i < 16; i++) begin
      if ({16'd0, call_q} >= 48'(i) * 48'(win)) rr_idx = 4'(i);
    end
  end

  // commit
  logic [3:0]  cur_d;
  logic [1:0]  mode;
  logic [31:0] base_dec, mstart_d;
  logic        started;
  always_comb begin
    cur_d    = cur_q;
    mode     = MODE_NONE;
    base_dec = 32'd0;
    if (decide_q) begin
      if (initial_q) begin
        cur_d = rr_idx; mode = MODE_INITIAL; base_dec = {16'd0, cfg_q.explore_length};
      end else if (random_q) begin
        cur_d = 4'(mrem_q); mode = MODE_RANDOM; base_dec = {16'd0, cfg_q.explore_length};
      end else begin
        if (found_q) cur_d = 4'(bidx_q);
        mode = MODE_EXPLOIT; base_dec = {8'd0, cfg_q.exploit_period};
      end
    end
    mstart_d = decide_q ? call_q + {16'd0, cfg_q.skip_length} : meas_start_q;
    started  = !item_q.func && (call_q == mstart_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      call_q       <= '0;
      next_dec_q   <= '0;
      meas_start_q <= '0;
      next_exp_q   <= '0;
      cur_q        <= '0;
      has_cur_q    <= 1'b0;
      snap_rt_q    <= '0;
      snap_tu_q    <= '0;
      tvalid_q     <= '0;
    end else if (cmd_i.commit) begin
      if (finish_q) tvalid_q[cur_q[IdxW-1:0]] <= 1'b1;
      if (decide_q) begin
        cur_q        <= cur_d;
        has_cur_q    <= 1'b1;
        meas_start_q <= mstart_d;
        next_dec_q   <= base_dec + mstart_d;
        if (!initial_q && random_q) next_exp_q <= next_exp_q + {8'd0, cfg_q.explore_period};
      end
      if (started) begin
        snap_rt_q <= item_q.runtime_total;
        snap_tu_q <= item_q.tuples_total;
      end
      if (!item_q.func) call_q <= call_q + 32'd1;
    end else if (cfg_pend_q && call_q == 32'd0) begin
      next_exp_q <= exp_start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && finish_q) table_q[cur_q[IdxW-1:0]] <= cost;
  end

  assign result_o.variant_index   = cur_d;
  assign result_o.decision_mode   = mode;
  assign result_o.measure_started = started;
  assign result_o.cost_valid      = finish_q;
  assign result_o.measured_cost   = cost;
endmodule

FILE: design/gvs_ctrl.sv
// Controller: sequences load, divide, modulo, scan and commit for one item.
module gvs_ctrl import gvs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dp_sts_t   sts_i,
  output dp_cmd_t   cmd_o,
  input  out_item_t result_i,
  output out_item_t result_o
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EVAL  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_MOD   = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_COMIT = 7'b0100000,
    S_HOLD  = 7'b1000000
  } state_e;

  state_e    state_q, state_d;
  logic      oval_q;
  out_item_t res_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: if (in_valid_i && !oval_q) begin
        cmd_o.load = 1'b1; state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.div_start  = 1'b1;
        cmd_o.mod_start  = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (sts_i.need_div && !sts_i.div_done) cmd_o.div_step = 1'b1;
        else state_d = S_MOD;
      end
      S_MOD: begin
        if (sts_i.need_mod && !sts_i.mod_done) cmd_o.mod_step = 1'b1;
        else state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.need_scan && !sts_i.scan_done) cmd_o.scan_step = 1'b1;
        else state_d = S_COMIT;
      end
      S_COMIT: begin
        cmd_o.commit = 1'b1; state_d = S_HOLD;
      end
      S_HOLD: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE) && !oval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.commit) oval_q <= 1'b1;
      else if (out_ready_i) oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_o.commit) res_q <= result_i;
  end

  assign out_valid_o = oval_q;
  assign result_o    = res_q;
endmodule

FILE: design/gvs_checker.sv
// Port checker for the greedy variant selector, bound to the top level.
module gvs_checker import gvs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");
  a_no_take_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while result pending");
  a_cost_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.cost_valid |-> out_item_o.measured_cost == 48'd0)
    else $error("cost without measurement");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result before work");
endmodule

bind greedy_variant_selector gvs_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_item_o
);

FILE: dv/greedy_variant_selector_tb.sv
// Testbench for the greedy variant selector: directed and random calls against a predictor.
`timescale 1ns / 100ps

module greedy_variant_selector_tb;
  import gvs_pkg::*;

  localparam int unsigned PoolMax   = 16;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned StallMax  = 20000;
  localparam int unsigned DrainWait = 200;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_item_t            in_item_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_item_o;

  greedy_variant_selector uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: a private copy of the selector's registers and table.
  cfg_t        cfg_q;
  logic [31:0] calls, decide_at, meas_at, explore_at;
  logic [3:0]  cur_variant;
  logic        in_use;
  logic [47:0] snap_rt;
  logic [39:0] snap_tu;
  logic [47:0] cost_tab [PoolMax];

  out_item_t   expected_q[$];
  int unsigned n_sent, n_checked, n_errors, n_modes[4], n_costs;
  int unsigned send_idle_pct, recv_stall_pct;

  function automatic logic [63:0] pool_eff();
    if (cfg_q.pool_size == 0) return 64'd1;
    if (cfg_q.pool_size > PoolMax) return 64'(PoolMax);
    return 64'(cfg_q.pool_size);
  endfunction

  function automatic logic [31:0] explore_first();
    logic [63:0] v;
    v = pool_eff() * (64'(cfg_q.skip_length) + 64'(cfg_q.explore_length))
        + 64'(cfg_q.explore_period);
    return cfg_q.initial_exploration ? v[31:0] : 32'd0;
  endfunction

  // Runtime per tuple, 16 fraction bits, saturated at 48 bits.
  function automatic logic [47:0] cost_per_tuple(logic [47:0] rt, logic [39:0] tu);
    logic [47:0] rd;
    logic [39:0] td;
    logic [63:0] q, r;
    rd = rt - snap_rt;
    td = tu - snap_tu;
    if (td == 0) return '0;
    q = 64'(rd) / 64'(td);
    r = 64'(rd) % 64'(td);
    if (q >= (64'd1 << (48 - FracBits))) return '1;
    return 48'((q << FracBits) + ((r << FracBits) / 64'(td)));
  endfunction

  task automatic predict_reset();
    cfg_q = '{pool_size: 5'd1, skip_length: 16'd0, explore_length: 16'd1,
              explore_period: 24'd1000, exploit_period: 24'd1000,
              initial_exploration: 1'b1};
    calls = 0; decide_at = 0; meas_at = 0;
    explore_at = explore_first();
    cur_variant = 0; in_use = 0; snap_rt = 0; snap_tu = 0;
    foreach (cost_tab[i]) cost_tab[i] = '0;
  endtask

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t   res;
    logic [63:0] pool, win, best;
    logic        found;
    res = '0;
    pool = pool_eff();
    win = 64'(cfg_q.skip_length) + 64'(cfg_q.explore_length);
    if (it.func) begin
      // finish query: closes the measurement, no decision, counter holds
      if (calls > meas_at && in_use) begin
        res.cost_valid = 1'b1;
        res.measured_cost = cost_per_tuple(it.runtime_total, it.tuples_total);
        cost_tab[cur_variant] = res.measured_cost;
      end
    end else begin
      if (calls == decide_at) begin
        if (in_use) begin
          res.cost_valid = 1'b1;
          res.measured_cost = cost_per_tuple(it.runtime_total, it.tuples_total);
          cost_tab[cur_variant] = res.measured_cost;
        end
        if (cfg_q.initial_exploration && win != 0 && 64'(calls) < pool * win) begin
          cur_variant = 4'(64'(calls) / win);
          decide_at = 32'(cfg_q.explore_length);
          res.decision_mode = MODE_INITIAL;
        end else if (calls >= explore_at) begin
          cur_variant = 4'(64'(it.random_value) % pool);
          decide_at = 32'(cfg_q.explore_length);
          explore_at = explore_at + 32'(cfg_q.explore_period);
          res.decision_mode = MODE_RANDOM;
        end else begin
          best = 0; found = 0;
          for (int i = 0; i < PoolMax && i < pool; i++) begin
            if (cost_tab[i] > 0 && (!found || 64'(cost_tab[i]) < best)) begin
              best = cost_tab[i]; found = 1; cur_variant = 4'(i);
            end
          end
          decide_at = 32'(cfg_q.exploit_period);
          res.decision_mode = MODE_EXPLOIT;
        end
        in_use = 1'b1;
        meas_at = calls + 32'(cfg_q.skip_length);
        decide_at = decide_at + meas_at;
      end
      if (calls == meas_at) begin
        snap_rt = it.runtime_total;
        snap_tu = it.tuples_total;
        res.measure_started = 1'b1;
      end
      calls = calls + 1;
    end
    res.variant_index = cur_variant;
    return res;
  endfunction

  // Register write while idle; mirrors the explore start rule.
  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_POOL_SIZE:      cfg_q.pool_size = val[4:0];
      CFG_SKIP_LENGTH:    cfg_q.skip_length = val[15:0];
      CFG_EXPLORE_LENGTH: cfg_q.explore_length = val[15:0];
      CFG_EXPLORE_PERIOD: cfg_q.explore_period = val[23:0];
      CFG_EXPLOIT_PERIOD: cfg_q.exploit_period = val[23:0];
      CFG_INITIAL_EXPL:   cfg_q.initial_exploration = val[0];
      default: ;
    endcase
    if (calls == 0) explore_at = explore_first();
  endtask

  task automatic set_config(logic [4:0] pool, logic [15:0] skip, logic [15:0] expl,
                            logic [23:0] eper, logic [23:0] xper, logic init);
    write_reg(CFG_POOL_SIZE, CfgDataW'(pool));
    write_reg(CFG_SKIP_LENGTH, CfgDataW'(skip));
    write_reg(CFG_EXPLORE_LENGTH, CfgDataW'(expl));
    write_reg(CFG_EXPLORE_PERIOD, eper);
    write_reg(CFG_EXPLOIT_PERIOD, xper);
    write_reg(CFG_INITIAL_EXPL, CfgDataW'(init));
  endtask

  // One transfer on the input channel; expectation queued at acceptance.
  // Valid is raised on a falling edge, after a random idle gap set by send_idle_pct.
  task automatic send_call(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(predict_result(it));
    n_sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drain();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  // Runtime and tuple totals mostly grow, so costs are meaningful.
  logic [47:0] rt_acc;
  logic [39:0] tu_acc;

  function automatic in_item_t make_call(bit query_ok);
    in_item_t it;
    it.func = query_ok && ($urandom_range(9) == 0);
    case ($urandom_range(9))
      0: begin
        it.runtime_total = 48'({$urandom, $urandom});
        it.tuples_total = 40'({$urandom, $urandom});
      end
      1: begin
        it.runtime_total = rt_acc + 48'($urandom);
        it.tuples_total = tu_acc;
      end
      default: begin
        rt_acc = rt_acc + 48'($urandom_range(100000));
        tu_acc = tu_acc + 40'($urandom_range(50));
        it.runtime_total = rt_acc;
        it.tuples_total = tu_acc;
      end
    endcase
    it.random_value = 16'($urandom);
    return it;
  endfunction

  task automatic run_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      case ((i * 4) / count)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      send_call(make_call(1'b1));
    end
  endtask

  // Extremes of the fields, a finish query before any call, zero tuple
  // delta, saturation and exploitation with no valid cost.
  task automatic test_directed();
    in_item_t it;
    send_idle_pct = 0; recv_stall_pct = 0;
    it = '{func: 1'b1, runtime_total: '1, tuples_total: '1, random_value: '1};
    send_call(it);
    it = '{func: 1'b0, runtime_total: '0, tuples_total: '0, random_value: '0};
    send_call(it);                         // initial exploration, snapshot
    it.func = 1'b1; it.runtime_total = '1; it.tuples_total = 40'd1;
    send_call(it);                         // saturated cost
    it.func = 1'b0; it.tuples_total = '0;
    send_call(it);                         // zero tuple delta
    it.runtime_total = 48'd5; it.tuples_total = '1; it.random_value = 16'hFFFF;
    for (int i = 0; i < 6; i++) send_call(it);
    wait_drain();
  endtask

  // Tight windows and a short period.
  task automatic test_small_windows();
    set_config(5'd4, 16'd1, 16'd2, 24'd5, 24'd3, 1'b1);
    run_random(240);
    wait_drain();
  endtask

  task automatic test_extremes();
    set_config(5'd0, 16'd0, 16'd1, 24'd0, 24'd1, 1'b0);     // pool 0 taken as 1
    run_random(120);
    wait_drain();
    set_config(5'd31, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    run_random(60);
    wait_drain();
    set_config(5'd16, 16'd0, 16'd1, 24'd7, 24'd2, 1'b1);
    run_random(260);
    wait_drain();
    set_config(5'd9, 16'd3, 16'd1, 24'd11, 24'd4, 1'b0);
    run_random(260);
    wait_drain();
  endtask

  // Result checker: compare each transfer with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item_o);
        n_errors++;
      end else begin
        exp_item = expected_q.pop_front();
        n_checked++;
        n_modes[exp_item.decision_mode]++;
        if (exp_item.cost_valid) n_costs++;
        if (out_item_o.variant_index !== exp_item.variant_index ||
            out_item_o.decision_mode !== exp_item.decision_mode ||
            out_item_o.measure_started !== exp_item.measure_started ||
            out_item_o.cost_valid !== exp_item.cost_valid ||
            out_item_o.measured_cost !== exp_item.measured_cost) begin
          $display("%0t: expected %h actual %h", $time, exp_item, out_item_o);
          n_errors++;
        end
      end
    end
  end

  // Receiver stall pattern.
  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  // Watchdog: cycles with no transfer on either channel.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      quiet_cycles <= 0;
    else if (quiet_cycles >= StallMax) begin
      $display("Mismatches found");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    rt_acc = '0; tu_acc = '0;
    send_idle_pct = 0; recv_stall_pct = 0;
    n_sent = 0; n_checked = 0; n_errors = 0; n_costs = 0;
    foreach (n_modes[i]) n_modes[i] = 0;
    predict_reset();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_small_windows();
    test_extremes();
    $display("Sent %0d items, checked %0d results, %0d costs measured", n_sent, n_checked,
             n_costs);
    $display("Decisions: initial %0d, random %0d, exploit %0d", n_modes[MODE_INITIAL],
             n_modes[MODE_RANDOM], n_modes[MODE_EXPLOIT]);
    if (n_errors == 0 && expected_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: greedy_variant_selector.f
design/gvs_pkg.sv
design/gvs_datapath.sv
design/gvs_ctrl.sv
design/greedy_variant_selector.sv
design/gvs_checker.sv
dv/greedy_variant_selector_tb.sv
